FILE: hdl/rsh_pkg.sv
package rsh_pkg;

  // Default fraction width of the fixed-point format.
  localparam int FRAC_BITS_DEF = 16;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 2;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

  localparam cfg_addr_t REG_CENTER_X = 2'd0;
  localparam cfg_addr_t REG_CENTER_Y = 2'd1;
  localparam cfg_addr_t REG_CENTER_Z = 2'd2;
  localparam cfg_addr_t REG_RADIUS   = 2'd3;

  // Register stages of the wide multiplier.
  localparam int MUL_LAT = 4;

endpackage

FILE: hdl/rsh_delay.sv
module rsh_delay #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d_in,
  output logic [W-1:0] d_out
);

  logic [W-1:0] tap_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d_in;
      for (int i = 1; i < N; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign d_out = tap_r[N-1];

endmodule

FILE: hdl/rsh_mul.sv
module rsh_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [AW-1:0]     a_i,
  input  logic signed [BW-1:0]     b_i,
  output logic signed [AW+BW-1:0]  p_o
);

  localparam int PW = AW + BW;

  logic [AW-1:0]  amag;
  logic [BW-1:0]  bmag;
  logic [63:0]    am_r, bm_r;
  logic           sg0_r, sg1_r, sg2_r;
  logic [63:0]    pp_r [4];
  logic [127:0]   sum_r;
  logic [PW-1:0]  p_r;

  // Magnitudes are split into 32-bit halves; four partial products follow.
  always_comb begin
    amag = a_i[AW-1] ? (~a_i + 1'b1) : a_i;
    bmag = b_i[BW-1] ? (~b_i + 1'b1) : b_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am_r  <= 64'(amag);
      bm_r  <= 64'(bmag);
      sg0_r <= a_i[AW-1] ^ b_i[BW-1];
      pp_r[0] <= am_r[31:0] * bm_r[31:0];
      pp_r[1] <= am_r[31:0] * bm_r[63:32];
      pp_r[2] <= am_r[63:32] * bm_r[31:0];
      pp_r[3] <= am_r[63:32] * bm_r[63:32];
      sg1_r <= sg0_r;
      sum_r <= 128'(pp_r[0]) + {32'd0, pp_r[1], 32'd0} + {32'd0, pp_r[2], 32'd0}
               + {pp_r[3], 64'd0};
      sg2_r <= sg1_r;
      p_r   <= sg2_r ? PW'(~sum_r + 1'b1) : PW'(sum_r);
    end
  end

  assign p_o = $signed(p_r);

endmodule

FILE: hdl/rsh_sqrt.sv
module rsh_sqrt #(
  parameter int IW = 118
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IW-1:0]     rad_i,
  output logic [IW/2-1:0]   root_o
);

  localparam int RW = IW / 2;

  logic [RW+1:0] rem_r  [RW];
  logic [RW-1:0] root_r [RW];
  logic [IW-1:0] val_r  [RW];

  // One result bit per stage: two radicand bits are brought down and the
  // trial value 4*root+1 is subtracted when it fits.
  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [RW+1:0] prem;
    logic [RW-1:0] proot;
    logic [IW-1:0] pval;
    logic [RW+1:0] rsh;
    logic [RW+1:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign prem  = '0;
      assign proot = '0;
      assign pval  = rad_i;
    end else begin : g_next
      assign prem  = rem_r[k-1];
      assign proot = root_r[k-1];
      assign pval  = val_r[k-1];
    end

    always_comb begin
      rsh   = {prem[RW-1:0], pval[IW-1 -: 2]};
      trial = {proot, 2'b01};
      ge    = (rsh >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? (rsh - trial) : rsh;
        root_r[k] <= {proot[RW-2:0], ge};
        val_r[k]  <= pval << 2;
      end
    end
  end

  assign root_o = root_r[RW-1];

endmodule

FILE: hdl/rsh_div.sv
module rsh_div #(
  parameter int NW  = 69,
  parameter int DVW = 48,
  parameter int QW  = 63
) (
  input  logic            clk,
  input  logic            en,
  input  logic [NW-1:0]   num_i,
  input  logic [DVW-1:0]  den_i,
  output logic [QW-1:0]   quo_o
);

  localparam int XW = (NW > DVW) ? NW : DVW;

  logic [DVW-1:0] rem_r [QW];
  logic [QW-1:0]  lq_r  [QW];
  logic [DVW-1:0] den_r [QW];

  // Restoring division, one quotient bit per stage. The quotient is known
  // to stay below 2**QW, so the bits above form the starting remainder.
  // The low numerator bits shift out of lq_r as quotient bits shift in.
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DVW-1:0] prem;
    logic [QW-1:0]  plq;
    logic [DVW-1:0] pden;
    logic [DVW:0]   tr;
    logic [DVW:0]   diff;
    logic           ge;

    if (k == 0) begin : g_first
      logic [XW-1:0] hi_x;
      assign hi_x = XW'(num_i >> QW);
      assign prem = hi_x[DVW-1:0];
      assign plq  = num_i[QW-1:0];
      assign pden = den_i;
    end else begin : g_next
      assign prem = rem_r[k-1];
      assign plq  = lq_r[k-1];
      assign pden = den_r[k-1];
    end

    always_comb begin
      tr   = {prem, plq[QW-1]};
      diff = tr - {1'b0, pden};
      ge   = (tr >= {1'b0, pden});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DVW-1:0] : tr[DVW-1:0];
        lq_r[k]  <= {plq[QW-2:0], ge};
        den_r[k] <= pden;
      end
    end
  end

  assign quo_o = lq_r[QW-1];

endmodule

FILE: hdl/ray_sphere_hit.sv
// Depth is set by the bit-serial square root and the two dividers in series.
// Throughput: one ray per clock cycle, sustained, as long as out_tready stays high.
// Reset (rst_n, synchronous, active low) empties the pipeline and the output stage,
// and loads the sphere registers with centre (0, 0, 0) and radius 1.0 at F = 16.
module ray_sphere_hit #(
  parameter int FRAC_BITS = rsh_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Configuration write channel.
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  rsh_pkg::cfg_addr_t      cfg_addr,
  input  logic [31:0]             cfg_wdata,
  // Ray input stream.
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // From bit 0 up: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_distance.
  input  logic [223:0]            in_tdata,
  // Result stream.
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // From bit 0 up: distance, normal_x, normal_y, normal_z.
  output logic [127:0]            out_tdata,
  // Bit 0: hit.
  output logic                    out_tuser
);

  import rsh_pkg::*;

  // ---------------------------------------------------------------------------
  // Widths. Offsets o = origin - centre take 33 bits. A = d.d, h = d.o and
  // C = o.o - r^2 are the exact dot products shifted down by FRAC_BITS. The
  // quarter discriminant D = h*h - A*C is exact and non-negative when the ray
  // can hit at all; its square root s has half its width.
  // ---------------------------------------------------------------------------
  localparam int AW   = 64 - FRAC_BITS;       // A, unsigned
  localparam int HW   = 66 - FRAC_BITS;       // h, signed
  localparam int CW   = 67 - FRAC_BITS;       // C, signed
  localparam int DSW  = 134 - 2 * FRAC_BITS;  // D, signed
  localparam int SW   = DSW / 2;              // s, unsigned
  localparam int NUMW = 69 - FRAC_BITS;       // -h - s, signed
  localparam int NMW  = NUMW + FRAC_BITS;     // |-h - s| scaled up
  localparam int PW   = 97;                   // o*2^F + t*d, signed
  localparam int QT   = 63;                   // quotient bits of the root
  localparam int QN   = 31;                   // quotient bits of a normal

  // Stage numbers: the register stage at which each value becomes available,
  // counting the first register after the input handshake as stage 1.
  localparam int ST_ABC  = 3;
  localparam int ST_MUL  = ST_ABC + MUL_LAT;
  localparam int ST_DISC = ST_MUL + 1;
  localparam int ST_S    = ST_DISC + SW;
  localparam int ST_NUM  = ST_S + 1;
  localparam int ST_DIV  = ST_NUM + 2;
  localparam int ST_Q    = ST_DIV + QT;
  localparam int ST_T    = ST_Q + 1;
  localparam int ST_HIT  = ST_T + 1;
  localparam int ST_PROD = ST_T + MUL_LAT;
  localparam int ST_NDIV = ST_PROD + 3;
  localparam int ST_END  = ST_NDIV + QN;

  typedef struct packed {
    logic        hit;
    logic [31:0] distance;
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] nz;
  } res_t;

  // ---------------------------------------------------------------------------
  // Configuration registers. The port never stalls; writes are expected only
  // while no ray is in flight, so the pipeline reads these directly.
  // ---------------------------------------------------------------------------
  logic signed [31:0] cx_r, cy_r, cz_r;
  logic [30:0]        rad_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      cz_r  <= '0;
      rad_r <= 31'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_CENTER_X: cx_r  <= cfg_wdata;
        REG_CENTER_Y: cy_r  <= cfg_wdata;
        REG_CENTER_Z: cz_r  <= cfg_wdata;
        REG_RADIUS:   rad_r <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. Every pipeline stage moves together on en. The output
  // register is backed by a skid register, so a result that waits on
  // out_tready does not stop new rays; only a full skid register does.
  // ---------------------------------------------------------------------------
  logic              en;
  logic [ST_END:1]   vld_r;
  res_t              fin;
  logic              out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;
  res_t              out_d_r, out_d_nxt, skid_d_r, skid_d_nxt;

  assign en        = !skid_v_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ST_END-1:1], in_tvalid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: offsets from the centre.
  // ---------------------------------------------------------------------------
  logic signed [31:0] org [3];
  logic signed [31:0] dir [3];
  logic signed [31:0] cen [3];
  logic signed [32:0] o_r [3];
  logic signed [31:0] d_r [3];
  logic signed [31:0] maxd_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      org[k] = in_tdata[32*k +: 32];
      dir[k] = in_tdata[96 + 32*k +: 32];
    end
    cen[0] = cx_r;
    cen[1] = cy_r;
    cen[2] = cz_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        o_r[k] <= {org[k][31], org[k]} - {cen[k][31], cen[k]};
        d_r[k] <= dir[k];
      end
      maxd_r <= in_tdata[192 +: 32];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the nine products of the dot products, and r^2.
  // ---------------------------------------------------------------------------
  logic signed [63:0] dd_r [3];
  logic signed [64:0] do_r [3];
  logic signed [65:0] oo_r [3];
  logic [61:0]        rr_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dd_r[k] <= d_r[k] * d_r[k];
        do_r[k] <= d_r[k] * o_r[k];
        oo_r[k] <= o_r[k] * o_r[k];
      end
      rr_r <= rad_r * rad_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: A, h and C, each rounded toward minus infinity.
  // ---------------------------------------------------------------------------
  logic signed [67:0]   sdd, sdo, soo;
  logic [AW-1:0]        a_r;
  logic signed [HW-1:0] h_r;
  logic signed [CW-1:0] c_r;

  always_comb begin
    sdd = 68'(dd_r[0]) + 68'(dd_r[1]) + 68'(dd_r[2]);
    sdo = 68'(do_r[0]) + 68'(do_r[1]) + 68'(do_r[2]);
    soo = 68'(oo_r[0]) + 68'(oo_r[1]) + 68'(oo_r[2]) - $signed({6'd0, rr_r});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= AW'(sdd >>> FRAC_BITS);
      h_r <= HW'(sdo >>> FRAC_BITS);
      c_r <= CW'(soo >>> FRAC_BITS);
    end
  end

  // ---------------------------------------------------------------------------
  // Discriminant: h*h and A*C on the split multipliers, then one subtract.
  // A negative discriminant is flagged and the root unit is fed zero.
  // ---------------------------------------------------------------------------
  logic signed [2*HW-1:0]    hh;
  logic signed [AW+CW:0]     ac;
  logic signed [DSW-1:0]     disc;
  logic [DSW-1:0]            sqin_r;
  logic                      dneg_r;

  rsh_mul #(.AW(HW), .BW(HW)) u_mul_hh (
    .clk (clk), .en (en), .a_i (h_r), .b_i (h_r), .p_o (hh)
  );

  rsh_mul #(.AW(AW + 1), .BW(CW)) u_mul_ac (
    .clk (clk), .en (en), .a_i ($signed({1'b0, a_r})), .b_i (c_r), .p_o (ac)
  );

  assign disc = DSW'(hh) - DSW'(ac);

  always_ff @(posedge clk) begin
    if (en) begin
      dneg_r <= disc[DSW-1];
      sqin_r <= disc[DSW-1] ? '0 : disc;
    end
  end

  // ---------------------------------------------------------------------------
  // Integer square root, one result bit per stage. A and h wait alongside.
  // ---------------------------------------------------------------------------
  logic [SW-1:0]        s_q;
  logic [AW+HW-1:0]     ah_d;
  logic [AW-1:0]        a_d;
  logic signed [HW-1:0] h_d;
  logic                 dneg_d;

  rsh_sqrt #(.IW(DSW)) u_sqrt (
    .clk (clk), .en (en), .rad_i (sqin_r), .root_o (s_q)
  );

  rsh_delay #(.W(AW + HW), .N(ST_S - ST_ABC)) u_dl_ah (
    .clk (clk), .en (en), .d_in ({h_r, a_r}), .d_out (ah_d)
  );

  rsh_delay #(.W(1), .N(ST_S - ST_DISC)) u_dl_dneg (
    .clk (clk), .en (en), .d_in (dneg_r), .d_out (dneg_d)
  );

  assign a_d = ah_d[AW-1:0];
  assign h_d = $signed(ah_d[AW+HW-1:AW]);

  // ---------------------------------------------------------------------------
  // Near-root numerator -h - s, and the miss conditions known so far: a
  // direction too short to give a nonzero A, a negative discriminant, or a
  // far root (s - h)/A behind the origin.
  // ---------------------------------------------------------------------------
  logic signed [NUMW-1:0] s_x, h_x, num_r;
  logic                   miss1_r, miss2_r, miss3_r;
  logic [AW-1:0]          a1_r, a2_r, a3_r;
  logic [NUMW-1:0]        nmag_r, nmag2_r;
  logic                   nneg_r, nneg2_r, rovf_r;

  always_comb begin
    s_x = $signed({2'b00, s_q});
    h_x = NUMW'(h_d);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r   <= -h_x - s_x;
      miss1_r <= dneg_d || (a_d == '0) || (s_x < h_x);
      a1_r    <= a_d;
      // Sign and magnitude for the unsigned divider.
      nneg_r  <= num_r[NUMW-1];
      nmag_r  <= num_r[NUMW-1] ? (~num_r + 1'b1) : num_r;
      miss2_r <= miss1_r;
      a2_r    <= a1_r;
      // The quotient reaches 2^63 exactly when |num| >= A * 2^(63-F); the
      // divider then need not produce it, as the result saturates.
      nmag2_r <= nmag_r;
      nneg2_r <= nneg_r;
      miss3_r <= miss2_r;
      a3_r    <= a2_r;
      rovf_r  <= (128'(nmag_r) >= (128'(a2_r) << (63 - FRAC_BITS)));
    end
  end

  // ---------------------------------------------------------------------------
  // Near root t = (-h - s) * 2^F / A, truncated toward zero, saturated to 64.
  // ---------------------------------------------------------------------------
  logic [QT-1:0]       tq;
  logic [2:0]          rside_d;
  logic [63:0]         tmag;
  logic signed [63:0]  t_r;
  logic                miss_t_r;

  rsh_div #(.NW(NMW), .DVW(AW), .QW(QT)) u_div_t (
    .clk   (clk),
    .en    (en),
    .num_i ({nmag2_r, {FRAC_BITS{1'b0}}}),
    .den_i (a3_r),
    .quo_o (tq)
  );

  rsh_delay #(.W(3), .N(ST_Q - ST_DIV)) u_dl_rside (
    .clk (clk), .en (en), .d_in ({miss3_r, rovf_r, nneg2_r}), .d_out (rside_d)
  );

  assign tmag = {1'b0, tq};

  always_ff @(posedge clk) begin
    if (en) begin
      if (rside_d[1]) begin
        t_r <= rside_d[0] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      end else begin
        t_r <= rside_d[0] ? $signed(~tmag + 1'b1) : $signed(tmag);
      end
      miss_t_r <= rside_d[2];
    end
  end

  // ---------------------------------------------------------------------------
  // Range test against max_distance, and the saturated distance field.
  // Direction and bound have travelled from stage 1 to meet t.
  // ---------------------------------------------------------------------------
  logic [127:0]       dm_d;
  logic signed [31:0] d_del [3];
  logic signed [31:0] maxd_del;
  logic               hit_r;
  logic [31:0]        dist_r;
  logic [32:0]        hd_d;

  rsh_delay #(.W(128), .N(ST_T - 1)) u_dl_dm (
    .clk   (clk),
    .en    (en),
    .d_in  ({maxd_r, d_r[2], d_r[1], d_r[0]}),
    .d_out (dm_d)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_del[k] = dm_d[32*k +: 32];
    end
    maxd_del = dm_d[96 +: 32];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= !miss_t_r && !(t_r > 64'(maxd_del));
      if (t_r > 64'sd2147483647) begin
        dist_r <= 32'h7FFF_FFFF;
      end else if (t_r < -64'sd2147483648) begin
        dist_r <= 32'h8000_0000;
      end else begin
        dist_r <= t_r[31:0];
      end
    end
  end

  rsh_delay #(.W(33), .N(ST_END - ST_HIT)) u_dl_hd (
    .clk (clk), .en (en), .d_in ({hit_r, dist_r}), .d_out (hd_d)
  );

  // ---------------------------------------------------------------------------
  // Normals, one lane per axis: ((o << F) + t*d) / r, truncated toward zero
  // and saturated to 32 bits. The overflow test |p| >= r * 2^31 stands in for
  // the quotient bits above the divider's width.
  // ---------------------------------------------------------------------------
  logic [98:0]        o_dl;
  logic [31:0]        nrm [3];

  rsh_delay #(.W(99), .N(ST_PROD - 1)) u_dl_o (
    .clk (clk), .en (en), .d_in ({o_r[2], o_r[1], o_r[0]}), .d_out (o_dl)
  );

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic signed [95:0]    prod;
    logic signed [32:0]    o_del;
    logic signed [PW-1:0]  p_r;
    logic [PW-1:0]         pmag_r, pmag2_r;
    logic                  pneg_r, pneg2_r, povf_r;
    logic [QN-1:0]         nq;
    logic [1:0]            nside_d;
    logic [31:0]           nqx;

    assign o_del = $signed(o_dl[33*k +: 33]);

    rsh_mul #(.AW(64), .BW(32)) u_mul_td (
      .clk (clk), .en (en), .a_i (t_r), .b_i (d_del[k]), .p_o (prod)
    );

    always_ff @(posedge clk) begin
      if (en) begin
        p_r     <= (PW'(o_del) <<< FRAC_BITS) + PW'(prod);
        pneg_r  <= p_r[PW-1];
        pmag_r  <= p_r[PW-1] ? (~p_r + 1'b1) : p_r;
        pneg2_r <= pneg_r;
        pmag2_r <= pmag_r;
        povf_r  <= (pmag_r >= (PW'(rad_r) << QN));
      end
    end

    rsh_div #(.NW(PW), .DVW(31), .QW(QN)) u_div_n (
      .clk (clk), .en (en), .num_i (pmag2_r), .den_i (rad_r), .quo_o (nq)
    );

    rsh_delay #(.W(2), .N(ST_END - ST_NDIV)) u_dl_nside (
      .clk (clk), .en (en), .d_in ({povf_r, pneg2_r}), .d_out (nside_d)
    );

    assign nqx = {1'b0, nq};

    always_comb begin
      if (nside_d[1]) begin
        nrm[k] = nside_d[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        nrm[k] = nside_d[0] ? (~nqx + 1'b1) : nqx;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result assembly. A miss reports all fields as zero; a zero radius keeps
  // the hit and distance but zeroes the normal.
  // ---------------------------------------------------------------------------
  always_comb begin
    fin = '0;
    if (hd_d[32]) begin
      fin.hit      = 1'b1;
      fin.distance = hd_d[31:0];
      if (rad_r != '0) begin
        fin.nx = nrm[0];
        fin.ny = nrm[1];
        fin.nz = nrm[2];
      end
    end
  end

  // Output register with skid register behind it.
  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = vld_r[ST_END];
        out_d_nxt = fin;
      end
    end else if (en && vld_r[ST_END]) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_d_r.hit;
  assign out_tdata  = {out_d_r.nz, out_d_r.ny, out_d_r.nx, out_d_r.distance};

endmodule

FILE: tb/sv/ray_sphere_hit_tb.sv
`timescale 1ns / 1ps

// Scoreboard for the sphere intersection unit. It holds its own copy of the
// sphere registers, predicts the answer of every accepted ray, and compares
// each result transaction in order against the oldest prediction.
class sphere_hit_board;
  typedef struct packed {
    logic        hit;
    logic [31:0] distance;
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] nz;
  } answer_t;

  logic signed [31:0] cx, cy, cz;
  logic [30:0]        rad;
  answer_t            pending[$];
  int                 mismatches;
  int                 checked;
  int                 hits;

  function new();
    cx = 0; cy = 0; cz = 0; rad = 31'd65536;
    mismatches = 0; checked = 0; hits = 0;
  endfunction

  function void write_reg(rsh_pkg::cfg_addr_t idx, logic [31:0] v);
    case (idx)
      rsh_pkg::REG_CENTER_X: cx = v;
      rsh_pkg::REG_CENTER_Y: cy = v;
      rsh_pkg::REG_CENTER_Z: cz = v;
      rsh_pkg::REG_RADIUS:   rad = v[30:0];
      default: ;
    endcase
  endfunction

  // Floor square root of a non-negative 128-bit value, bit by bit.
  function automatic logic [63:0] root_floor(logic [127:0] v);
    logic [63:0]  r;
    logic [63:0]  c;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  // Signed 128-bit division truncated toward zero, positive divisor.
  function automatic logic signed [127:0] div_trunc(logic signed [127:0] n,
                                                     logic [63:0] d);
    logic [127:0] m;
    logic [127:0] q;
    m = n[127] ? -n : n;
    q = m / {64'd0, d};
    return n[127] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [31:0] clip32(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'h7fffffff;
    if (v < -128'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Note an accepted ray and queue the answer the unit should give.
  function void note_ray(logic [223:0] ray);
    logic signed [127:0] o[3], d[3];
    logic signed [127:0] aa, hh, cc, disc, s, num, tq, t, maxd, p;
    answer_t ans;
    ans = '0;
    o[0] = $signed(ray[31:0]) - cx;
    o[1] = $signed(ray[63:32]) - cy;
    o[2] = $signed(ray[95:64]) - cz;
    d[0] = $signed(ray[127:96]);
    d[1] = $signed(ray[159:128]);
    d[2] = $signed(ray[191:160]);
    maxd = $signed(ray[223:192]);
    // Arithmetic shifts floor toward minus infinity, as the unit does.
    aa = (d[0]*d[0] + d[1]*d[1] + d[2]*d[2]) >>> 16;
    hh = (d[0]*o[0] + d[1]*o[1] + d[2]*o[2]) >>> 16;
    cc = (o[0]*o[0] + o[1]*o[1] + o[2]*o[2]
          - $signed({97'd0, rad}) * $signed({97'd0, rad})) >>> 16;
    if (aa != 0) begin
      disc = hh*hh - aa*cc;
      if (!disc[127]) begin
        s = $signed({64'd0, root_floor(disc)});
        if (s - hh >= 0) begin
          num = -hh - s;
          tq = div_trunc(num <<< 16, aa[63:0]);
          if (tq > 128'sh7fffffffffffffff) t = 128'sh7fffffffffffffff;
          else if (tq < -128'sh8000000000000000) t = -128'sh8000000000000000;
          else t = tq;
          if (t <= maxd) begin
            ans.hit = 1'b1;
            ans.distance = clip32(t);
            if (rad != 0) begin
              p = (o[0] <<< 16) + t*d[0];
              ans.nx = clip32(div_trunc(p, {33'd0, rad}));
              p = (o[1] <<< 16) + t*d[1];
              ans.ny = clip32(div_trunc(p, {33'd0, rad}));
              p = (o[2] <<< 16) + t*d[2];
              ans.nz = clip32(div_trunc(p, {33'd0, rad}));
            end
          end
        end
      end
    end
    pending.push_back(ans);
  endfunction

  function void check_result(logic hit, logic [127:0] data);
    answer_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: hit=%0b data=%h", hit, data);
      return;
    end
    want = pending.pop_front();
    checked++;
    if (want.hit) hits++;
    if (hit !== want.hit || data[31:0] !== want.distance || data[63:32] !== want.nx
        || data[95:64] !== want.ny || data[127:96] !== want.nz) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %0d: want hit=%0b t=%h n=%h,%h,%h got hit=%0b t=%h n=%h,%h,%h",
                 checked, want.hit, want.distance, want.nx, want.ny, want.nz,
                 hit, data[31:0], data[63:32], data[95:64], data[127:96]);
    end
  endfunction
endclass

module ray_sphere_hit_tb;
  import rsh_pkg::*;

  localparam int LATENCY = 165;
  localparam longint CYCLE_LIMIT = 400000;

  logic         clk;
  logic         rst_n;
  logic         cfg_valid;
  logic         cfg_ready;
  cfg_addr_t    cfg_addr;
  logic [31:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [223:0] in_tdata;   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_distance
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;  // distance, normal_x, normal_y, normal_z
  logic         out_tuser;  // hit

  sphere_hit_board board;
  longint cycles;
  int     rays_sent;

  ray_sphere_hit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // The cycle counter is the watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Result side: every transaction is checked at the rising edge where it
  // completes. Ready is redrawn at the falling edge with random stalls,
  // and now and again a long run of continuous ready.
  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tuser, out_tdata);

  initial begin
    int stall;
    int steady;
    out_tready = 1'b0;
    steady = 0;
    forever begin
      @(negedge clk);
      if (steady > 0) begin
        steady--;
        out_tready = 1'b1;
      end else if ($urandom_range(0, 15) == 0) begin
        steady = $urandom_range(20, 200);
        out_tready = 1'b1;
      end else begin
        stall = $urandom_range(0, 5);
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
        out_tready = 1'b1;
      end
    end
  end

  task automatic write_cfg(cfg_addr_t idx, logic [31:0] v);
    cfg_addr  = idx;
    cfg_wdata = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Sends one ray after a random gap; bursts of zero gap come from the draw.
  task automatic send_ray(logic [223:0] ray);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = ray;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    board.note_ray(ray);
    rays_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  function automatic logic [223:0] pack_ray(logic [31:0] ox, oy, oz, dx, dy, dz, md);
    return {md, dz, dy, dx, oz, oy, ox};
  endfunction

  // Coordinates of a random flavour: mostly a few units, sometimes anything.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
      2: return 32'd0;
      default: return $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
    endcase
  endfunction

  function automatic logic [31:0] pick_max();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h7fffffff;
      default: return $urandom_range(0, 30 * 65536);
    endcase
  endfunction

  // A ray aimed near the sphere centre, so that most of them hit.
  function automatic logic [223:0] aimed_ray();
    logic signed [31:0] ox, oy, oz, tx, ty, tz, sc;
    ox = $signed($urandom_range(0, 16 * 65536)) - 8 * 65536;
    oy = $signed($urandom_range(0, 16 * 65536)) - 8 * 65536;
    oz = $signed($urandom_range(0, 16 * 65536)) - 8 * 65536;
    tx = board.cx + $signed($urandom_range(0, 65536)) - 32768;
    ty = board.cy + $signed($urandom_range(0, 65536)) - 32768;
    tz = board.cz + $signed($urandom_range(0, 65536)) - 32768;
    sc = $urandom_range(1, 4);
    return pack_ray(ox + board.cx, oy + board.cy, oz + board.cz,
                    (tx - ox - board.cx) / sc, (ty - oy - board.cy) / sc,
                    (tz - oz - board.cz) / sc, pick_max());
  endfunction

  initial begin
    logic [31:0] one;
    one = 32'd65536;
    board = new();
    cycles = 0;
    rays_sent = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_addr = REG_CENTER_X;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed rays against the reset sphere (unit radius at the origin).
    send_ray(pack_ray(-5 * one, 0, 0, one, 0, 0, 32'h7fffffff));    // plain hit
    send_ray(pack_ray(-5 * one, 0, 0, 0, 0, 0, 32'h7fffffff));      // zero direction
    send_ray(pack_ray(-5 * one, 0, 0, 1, 0, 0, 32'h7fffffff));      // direction too short
    send_ray(pack_ray(-5 * one, 5 * one, 0, one, 0, 0, 32'h7fffffff)); // clean miss
    send_ray(pack_ray(-5 * one, one, 0, one, 0, 0, 32'h7fffffff));  // tangent ahead
    send_ray(pack_ray(5 * one, one, 0, one, 0, 0, 32'h7fffffff));   // tangent behind
    send_ray(pack_ray(5 * one, 0, 0, one, 0, 0, 32'h7fffffff));     // sphere behind
    send_ray(pack_ray(0, 0, 0, 0, one, 0, 32'h7fffffff));           // origin inside
    send_ray(pack_ray(-5 * one, 0, 0, one, 0, 0, 3 * one));         // beyond the bound
    send_ray(pack_ray(-5 * one, 0, 0, one, 0, 0, 4 * one));         // exactly on the bound
    send_ray(pack_ray(-5 * one, 0, 0, one, 0, 0, 32'h80000000));    // most negative bound
    send_ray(pack_ray(32'h80000000, 0, 0, 32'h7fffffff, 0, 0, 32'h7fffffff));
    send_ray(pack_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                      32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff));
    send_ray(pack_ray(32'hffffffff, 32'hffffffff, 32'hffffffff,
                      32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff));
    send_ray(pack_ray(-3 * one, 0, 0, 32'h00000100, 0, 0, 32'h7fffffff)); // far hit, short direction
    drain();

    // Zero radius, then the largest sphere at extreme centres.
    write_cfg(REG_RADIUS, 32'd0);
    send_ray(pack_ray(-5 * one, 0, 0, one, 0, 0, 32'h7fffffff));
    send_ray(pack_ray(0, 0, 0, one, 0, 0, 32'h7fffffff));
    drain();
    write_cfg(REG_RADIUS, 32'h7fffffff);
    write_cfg(REG_CENTER_X, 32'h7fffffff);
    write_cfg(REG_CENTER_Y, 32'h80000000);
    write_cfg(REG_CENTER_Z, 32'h80000000);
    send_ray(pack_ray(32'h80000000, 32'h7fffffff, 32'h7fffffff, one, 0, 0, 32'h7fffffff));
    send_ray(pack_ray(0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff));
    drain();

    // Random phases, each with fresh sphere registers.
    for (int phase = 0; phase < 8; phase++) begin
      write_cfg(REG_CENTER_X, (phase == 7) ? $urandom() : pick_coord());
      write_cfg(REG_CENTER_Y, (phase == 7) ? $urandom() : pick_coord());
      write_cfg(REG_CENTER_Z, (phase == 7) ? $urandom() : pick_coord());
      case (phase % 4)
        0: write_cfg(REG_RADIUS, $urandom_range(1, 4 * 65536));
        1: write_cfg(REG_RADIUS, $urandom());
        2: write_cfg(REG_RADIUS, $urandom_range(0, 255));
        default: write_cfg(REG_RADIUS, $urandom_range(32768, 6 * 65536));
      endcase
      for (int k = 0; k < 230; k++) begin
        if ($urandom_range(0, 9) < 6)
          send_ray(aimed_ray());
        else if ($urandom_range(0, 3) == 0)
          send_ray({$urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom(), $urandom()});
        else
          send_ray(pack_ray(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                            pick_coord(), pick_coord(), pick_max()));
      end
      drain();
    end

    $display("rays sent %0d, results checked %0d, of which hits %0d",
             rays_sent, board.checked, board.hits);
    $display("covered reset sphere, zero and full radius, extreme centres and random spheres");
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", board.mismatches, board.pending.size());
      $display("status: fail");
    end
    $finish;
  end
endmodule

FILE: files.f
hdl/rsh_pkg.sv
hdl/rsh_delay.sv
hdl/rsh_mul.sv
hdl/rsh_sqrt.sv
hdl/rsh_div.sv
hdl/ray_sphere_hit.sv
tb/sv/ray_sphere_hit_tb.sv
